// ===== rtl/qrt_pkg.sv =====
package qrt_pkg;

   typedef struct packed {
      logic signed [15:0] cur_w;
      logic signed [15:0] cur_x;
      logic signed [15:0] cur_y;
      logic signed [15:0] cur_z;
      logic signed [15:0] tgt_w;
      logic signed [15:0] tgt_x;
      logic signed [15:0] tgt_y;
      logic signed [15:0] tgt_z;
      logic        [15:0] step_limit;
   } req_word_type;

   typedef struct packed {
      logic signed [15:0] out_w;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
      logic        [1:0]  outcome;
   } rsp_word_type;

   localparam logic [1:0] OUTCOME_KEEP   = 2'd0;
   localparam logic [1:0] OUTCOME_TARGET = 2'd1;
   localparam logic [1:0] OUTCOME_INTERP = 2'd2;

   localparam logic [15:0] PI_Q14     = 16'd51472;
   localparam logic [15:0] TINY_LIMIT = 16'd17;
   localparam logic signed [33:0] DOT_SNAP = 34'sd1073634449;
   localparam logic [30:0] ONE_Q30    = 31'd1073741824;
   localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;
   localparam int CORDIC_STEPS = 16;

   function automatic logic signed [17:0] atan_q16(input logic [3:0] i);
      logic signed [17:0] r;
      case (i)
         4'd0: r = 18'sd51472;
         4'd1: r = 18'sd30386;
         4'd2: r = 18'sd16055;
         4'd3: r = 18'sd8150;
         4'd4: r = 18'sd4091;
         4'd5: r = 18'sd2047;
         4'd6: r = 18'sd1024;
         4'd7: r = 18'sd512;
         4'd8: r = 18'sd256;
         4'd9: r = 18'sd128;
         4'd10: r = 18'sd64;
         4'd11: r = 18'sd32;
         4'd12: r = 18'sd16;
         4'd13: r = 18'sd8;
         4'd14: r = 18'sd4;
         default: r = 18'sd2;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic [1:0] outcome;
      logic       done;
   } ctl_type;

endpackage

// ===== rtl/qrt_sqrt.sv =====
module qrt_sqrt
   import qrt_pkg::*;
#(
   parameter int W = 62,
   parameter int TW = 8
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [W-1:0]    in_rad,
   input  logic [TW-1:0]   in_tag,
   output logic            out_valid,
   output logic [W/2-1:0]  out_root,
   output logic [TW-1:0]   out_tag
);
   localparam int N = W / 2;

   logic [N:0]     vld_ff;
   logic [W-1:0]   rem_ff  [N+1];
   logic [N-1:0]   root_ff [N+1];
   logic [W-1:0]   rad_ff  [N+1];
   logic [TW-1:0]  tag_ff  [N+1];

   always_comb begin
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      rad_ff[0]  = in_rad;
      tag_ff[0]  = in_tag;
      vld_ff[0]  = in_valid;
   end

   for (genvar s = 0; s < N; s++) begin : g_st
      logic [W-1:0] rem_in;
      logic [W-1:0] trial;
      logic [N-1:0] root_in;
      always_comb begin
         rem_in = {rem_ff[s][W-3:0], rad_ff[s][W-1-2*s -: 2]};
         trial  = {{(W-N-2){1'b0}}, root_ff[s], 2'b01};
         if (rem_in >= trial) begin
            rem_in  = rem_in - trial;
            root_in = {root_ff[s][N-2:0], 1'b1};
         end else begin
            root_in = {root_ff[s][N-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (adv) begin
            rem_ff[s+1]  <= rem_in;
            root_ff[s+1] <= root_in;
            rad_ff[s+1]  <= rad_ff[s];
            tag_ff[s+1]  <= tag_ff[s];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_root  = root_ff[N];
   assign out_tag   = tag_ff[N];
endmodule

// ===== rtl/qrt_cordic.sv =====
module qrt_cordic
   import qrt_pkg::*;
#(
   parameter int TW = 8
)(
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic               vec_mode,
   input  logic signed [33:0] in_x,
   input  logic signed [33:0] in_y,
   input  logic signed [19:0] in_z,
   input  logic [TW-1:0]      in_tag,
   output logic               out_valid,
   output logic signed [33:0] out_y,
   output logic signed [19:0] out_z,
   output logic [TW-1:0]      out_tag
);
   localparam int N = CORDIC_STEPS;

   logic               vld_ff [N+1];
   logic signed [33:0] x_ff   [N+1];
   logic signed [33:0] y_ff   [N+1];
   logic signed [19:0] z_ff   [N+1];
   logic [TW-1:0]      tag_ff [N+1];

   always_comb begin
      vld_ff[0] = in_valid;
      x_ff[0]   = in_x;
      y_ff[0]   = in_y;
      z_ff[0]   = in_z;
      tag_ff[0] = in_tag;
   end

   for (genvar i = 0; i < N; i++) begin : g_it
      logic signed [33:0] dx, dy, x_in, y_in;
      logic signed [19:0] z_in;
      logic               pos;
      always_comb begin
         dx  = y_ff[i] >>> i;
         dy  = x_ff[i] >>> i;
         pos = vec_mode ? (y_ff[i] > 0) : (z_ff[i] >= 0);
         if (vec_mode == pos) begin
            x_in = x_ff[i] + dx;
            y_in = y_ff[i] - dy;
         end else begin
            x_in = x_ff[i] - dx;
            y_in = y_ff[i] + dy;
         end
         if (vec_mode) begin
            z_in = pos ? z_ff[i] + 20'(atan_q16(4'(i))) : z_ff[i] - 20'(atan_q16(4'(i)));
         end else begin
            z_in = pos ? z_ff[i] - 20'(atan_q16(4'(i))) : z_ff[i] + 20'(atan_q16(4'(i)));
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (adv) begin
            x_ff[i+1]   <= x_in;
            y_ff[i+1]   <= y_in;
            z_ff[i+1]   <= z_in;
            tag_ff[i+1] <= tag_ff[i];
         end
      end
   end

   assign out_valid = vld_ff[N];
   assign out_y     = y_ff[N];
   assign out_z     = z_ff[N];
   assign out_tag   = tag_ff[N];
endmodule

// ===== rtl/qrt_divider.sv =====
module qrt_divider
   import qrt_pkg::*;
#(
   parameter int NW = 48,
   parameter int DW = 32,
   parameter int QW = 17
)(
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [NW-1:0]   in_num,
   input  logic [DW-1:0]   in_den,
   output logic            out_valid,
   output logic [QW-1:0]   out_quo
);
   // restoring division, only the low QW quotient bits are kept (saturated)
   localparam int RW = NW + 1;

   logic            vld_ff [NW+1];
   logic [RW-1:0]   rem_ff [NW+1];
   logic [NW-1:0]   num_ff [NW+1];
   logic [DW-1:0]   den_ff [NW+1];
   logic [QW-1:0]   quo_ff [NW+1];
   logic            big_ff [NW+1];

   always_comb begin
      vld_ff[0] = in_valid;
      rem_ff[0] = '0;
      num_ff[0] = in_num;
      den_ff[0] = in_den;
      quo_ff[0] = '0;
      big_ff[0] = 1'b0;
   end

   for (genvar s = 0; s < NW; s++) begin : g_st
      logic [RW-1:0] r_in;
      logic          bit_q;
      always_comb begin
         r_in  = {rem_ff[s][RW-2:0], num_ff[s][NW-1-s]};
         bit_q = (r_in >= RW'(den_ff[s]));
         if (bit_q) begin
            r_in = r_in - RW'(den_ff[s]);
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (adv) begin
            rem_ff[s+1] <= r_in;
            num_ff[s+1] <= num_ff[s];
            den_ff[s+1] <= den_ff[s];
            quo_ff[s+1] <= {quo_ff[s][QW-2:0], bit_q};
            big_ff[s+1] <= big_ff[s] | quo_ff[s][QW-1];
         end
      end
   end

   assign out_valid = vld_ff[NW];
   assign out_quo   = big_ff[NW] ? '1 : quo_ff[NW];
endmodule

// ===== rtl/quaternion_rotate_towards.sv =====
// channel | dir | payload       | handshake
// req     | in  | req_word_type | req_valid / req_stall
// rsp     | out | rsp_word_type | rsp_valid / rsp_stall
// one word accepted per cycle while req_stall is low; words pass through the two
// square-root pipelines, the angle cordic, the sine cordics (side by side) and
// the divider pipeline in series. reset clears only the valid bits. rsp_stall with
// rsp_valid high freezes the whole pipeline; the output register is never overwritten while stalled.
module quaternion_rotate_towards
   import qrt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);
   // everything the later stages need rides as a tag
   typedef struct packed {
      req_word_type w;
      logic [15:0]  lim;
      logic         neg;
      ctl_type      ctl;
   } tag_type;
   localparam int TW = $bits(tag_type);

   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 1: limit saturate, products
   logic               s1_vld_ff;
   req_word_type       s1_w_ff;
   logic [15:0]        s1_lim_ff;
   logic signed [31:0] s1_p_ff [4];
   logic [15:0]        lim_in;
   assign lim_in = (req_word.step_limit > PI_Q14) ? PI_Q14 : req_word.step_limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= req_valid;
      end
      if (adv) begin
         s1_w_ff   <= req_word;
         s1_lim_ff <= lim_in;
         s1_p_ff[0] <= req_word.cur_w * req_word.tgt_w;
         s1_p_ff[1] <= req_word.cur_x * req_word.tgt_x;
         s1_p_ff[2] <= req_word.cur_y * req_word.tgt_y;
         s1_p_ff[3] <= req_word.cur_z * req_word.tgt_z;
      end
   end

   // stage 2: dot, decisions, clamp
   logic signed [34:0] dot_in;
   logic [30:0]        c_in;
   logic               neg_in;
   ctl_type            ctl_in;
   always_comb begin
      dot_in = (35'(s1_p_ff[0]) + 35'(s1_p_ff[1]) + 35'(s1_p_ff[2]) + 35'(s1_p_ff[3])) <<< 1;
      neg_in = dot_in < 0;
      if (neg_in) begin
         c_in = (-dot_in > 35'(ONE_Q30)) ? ONE_Q30 : 31'(-dot_in);
      end else begin
         c_in = (dot_in > 35'(ONE_Q30)) ? ONE_Q30 : 31'(dot_in);
      end
      if (s1_lim_ff < TINY_LIMIT) begin
         ctl_in = '{outcome: OUTCOME_KEEP, done: 1'b1};
      end else if (dot_in > DOT_SNAP) begin
         ctl_in = '{outcome: OUTCOME_TARGET, done: 1'b1};
      end else begin
         ctl_in = '{outcome: OUTCOME_INTERP, done: 1'b0};
      end
   end

   logic        s2_vld_ff;
   tag_type     s2_tag_ff;
   logic [30:0] s2_c_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (adv) begin
         s2_tag_ff <= '{w: s1_w_ff, lim: s1_lim_ff, neg: neg_in, ctl: ctl_in};
         s2_c_ff   <= c_in;
      end
   end

   // stage 3: 2^60 - c*c
   logic        s3_vld_ff;
   tag_type     s3_tag_ff;
   logic [30:0] s3_c_ff;
   logic [61:0] s3_rad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (adv) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (adv) begin
         s3_tag_ff <= s2_tag_ff;
         s3_c_ff   <= s2_c_ff;
         s3_rad_ff <= (62'd1 << 60) - (62'(s2_c_ff) * 62'(s2_c_ff));
      end
   end

   logic          sq1_vld;
   logic [30:0]   sq1_root;
   logic [TW+30:0] sq1_tag;
   qrt_sqrt #(.W(62), .TW(TW + 31)) u_sqrt_s (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s3_vld_ff), .in_rad(s3_rad_ff), .in_tag({s3_tag_ff, s3_c_ff}),
      .out_valid(sq1_vld), .out_root(sq1_root), .out_tag(sq1_tag)
   );

   logic               an_vld;
   logic signed [19:0] an_z;
   logic signed [33:0] an_y;
   logic [TW-1:0]      an_tag;
   qrt_cordic #(.TW(TW)) u_angle (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(sq1_vld), .vec_mode(1'b1),
      .in_x(34'(sq1_tag[30:0])), .in_y(34'(sq1_root)), .in_z('0),
      .in_tag(sq1_tag[TW+30:31]),
      .out_valid(an_vld), .out_y(an_y), .out_z(an_z), .out_tag(an_tag)
   );

   // stage: theta compare, sine arguments
   tag_type            an_t;
   logic signed [19:0] th;
   logic signed [19:0] l16;
   tag_type            sa_tag_in;
   assign an_t = an_tag;
   assign th   = (an_z < 0) ? '0 : an_z;
   assign l16  = 20'(an_t.lim) <<< 2;

   always_comb begin
      sa_tag_in = an_t;
      if (!an_t.ctl.done && th < l16) begin
         sa_tag_in.ctl = '{outcome: OUTCOME_TARGET, done: 1'b1};
      end
   end

   logic               sa_vld_ff;
   tag_type            sa_tag_ff;
   logic signed [19:0] sa_za_ff, sa_zb_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         sa_vld_ff <= 1'b0;
      end else if (adv) begin
         sa_vld_ff <= an_vld;
      end
      if (adv) begin
         sa_tag_ff <= sa_tag_in;
         sa_za_ff <= th - l16;
         sa_zb_ff <= l16;
      end
   end

   logic               sn_vld;
   logic signed [33:0] sin_a, sin_b;
   logic signed [19:0] za_unused, zb_unused;
   logic [TW-1:0]      sn_tag, sb_tag;
   logic               sb_vld;
   qrt_cordic #(.TW(TW)) u_sin_a (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(sa_vld_ff), .vec_mode(1'b0),
      .in_x(34'(GAIN_Q30)), .in_y('0), .in_z(sa_za_ff), .in_tag(sa_tag_ff),
      .out_valid(sn_vld), .out_y(sin_a), .out_z(za_unused), .out_tag(sn_tag)
   );
   qrt_cordic #(.TW(TW)) u_sin_b (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(sa_vld_ff), .vec_mode(1'b0),
      .in_x(34'(GAIN_Q30)), .in_y('0), .in_z(sa_zb_ff), .in_tag(sa_tag_ff),
      .out_valid(sb_vld), .out_y(sin_b), .out_z(zb_unused), .out_tag(sb_tag)
   );

   // products a*cur and b*tgt
   tag_type            sn_t;
   logic signed [16:0] cq [4];
   logic signed [15:0] tq [4];
   assign sn_t = sn_tag;
   always_comb begin
      cq[0] = 17'(sn_t.w.cur_w); cq[1] = 17'(sn_t.w.cur_x);
      cq[2] = 17'(sn_t.w.cur_y); cq[3] = 17'(sn_t.w.cur_z);
      tq[0] = sn_t.w.tgt_w; tq[1] = sn_t.w.tgt_x;
      tq[2] = sn_t.w.tgt_y; tq[3] = sn_t.w.tgt_z;
      for (int k = 0; k < 4; k++) begin
         if (sn_t.neg) cq[k] = -cq[k];
      end
   end

   logic               pm_vld_ff;
   tag_type            pm_tag_ff;
   logic signed [48:0] pa_ff [4];
   logic signed [48:0] pb_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         pm_vld_ff <= 1'b0;
      end else if (adv) begin
         pm_vld_ff <= sn_vld & sb_vld;
      end
      if (adv) begin
         pm_tag_ff <= sn_t;
         for (int k = 0; k < 4; k++) begin
            pa_ff[k] <= 49'(sin_a) * 49'(cq[k]);
            pb_ff[k] <= 49'(sin_b) * 49'(tq[k]);
         end
      end
   end

   logic               v_vld_ff;
   tag_type            v_tag_ff;
   logic signed [33:0] v_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         v_vld_ff <= 1'b0;
      end else if (adv) begin
         v_vld_ff <= pm_vld_ff;
      end
      if (adv) begin
         v_tag_ff <= pm_tag_ff;
         for (int k = 0; k < 4; k++) begin
            v_ff[k] <= 34'((50'(pa_ff[k]) + 50'(pb_ff[k])) >>> 16);
         end
      end
   end

   logic               q_vld_ff;
   tag_type            q_tag_ff;
   logic signed [33:0] q_v_ff [4];
   logic [63:0]        q_sq_ff [4];
   always_ff @(posedge clock) begin
      if (reset) begin
         q_vld_ff <= 1'b0;
      end else if (adv) begin
         q_vld_ff <= v_vld_ff;
      end
      if (adv) begin
         q_tag_ff <= v_tag_ff;
         for (int k = 0; k < 4; k++) begin
            q_v_ff[k]  <= v_ff[k];
            q_sq_ff[k] <= 64'(v_ff[k] * v_ff[k]);
         end
      end
   end

   logic        ss_vld_ff;
   logic [65:0] ss_sum_ff;
   logic [TW+135:0] ss_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ss_vld_ff <= 1'b0;
      end else if (adv) begin
         ss_vld_ff <= q_vld_ff;
      end
      if (adv) begin
         ss_sum_ff <= 66'(q_sq_ff[0]) + 66'(q_sq_ff[1]) + 66'(q_sq_ff[2])
                    + 66'(q_sq_ff[3]);
         ss_tag_ff <= {q_tag_ff, q_v_ff[0], q_v_ff[1], q_v_ff[2], q_v_ff[3]};
      end
   end

   logic            n_vld;
   logic [32:0]     n_root;
   logic [TW+135:0] n_tag;
   qrt_sqrt #(.W(66), .TW(TW + 136)) u_sqrt_n (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(ss_vld_ff), .in_rad(ss_sum_ff), .in_tag(ss_tag_ff),
      .out_valid(n_vld), .out_root(n_root), .out_tag(n_tag)
   );

   // numerators mag*32768 + n/2
   logic signed [33:0] nv [4];
   logic [49:0]        num [4];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         nv[k]  = n_tag[135-34*k -: 34];
         num[k] = ({16'd0, (nv[k] < 0) ? 34'(-nv[k]) : nv[k]} << 15) + 50'(n_root >> 1);
      end
   end

   logic        dv_vld_ff;
   logic [49:0] dv_num_ff [4];
   logic [32:0] dv_den_ff;
   logic [TW+3:0] dv_tag_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         dv_vld_ff <= 1'b0;
      end else if (adv) begin
         dv_vld_ff <= n_vld;
      end
      if (adv) begin
         for (int k = 0; k < 4; k++) begin
            dv_num_ff[k] <= num[k];
         end
         dv_den_ff <= n_root;
         dv_tag_ff <= {n_tag[TW+135:136], nv[0] < 0, nv[1] < 0, nv[2] < 0, nv[3] < 0};
      end
   end

   logic        dq_vld [4];
   logic [16:0] dq [4];
   for (genvar k = 0; k < 4; k++) begin : g_div
      qrt_divider #(.NW(50), .DW(33), .QW(17)) u_div (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(dv_vld_ff), .in_num(dv_num_ff[k]), .in_den(dv_den_ff),
         .out_valid(dq_vld[k]), .out_quo(dq[k])
      );
   end

   // tag pipe alongside the dividers
   localparam int DL = 50;
   logic [TW+3:0] dt_ff [DL+1];
   logic [32:0]   dn_ff [DL+1];
   always_comb begin
      dt_ff[0] = dv_tag_ff;
      dn_ff[0] = dv_den_ff;
   end
   for (genvar s = 0; s < DL; s++) begin : g_dt
      always_ff @(posedge clock) begin
         if (adv) begin
            dt_ff[s+1] <= dt_ff[s];
            dn_ff[s+1] <= dn_ff[s];
         end
      end
   end

   tag_type       fin_t;
   logic [3:0]    fin_neg;
   logic signed [15:0] res [4];
   rsp_word_type  rsp_in;
   assign fin_t   = dt_ff[DL][TW+3:4];
   assign fin_neg = dt_ff[DL][3:0];
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         if (dn_ff[DL] == '0) begin
            res[k] = '0;
         end else if (fin_neg[3-k]) begin
            res[k] = (dq[k] > 17'd32768) ? 16'sh8000 : 16'(-dq[k]);
         end else begin
            res[k] = (dq[k] > 17'd32767) ? 16'sh7fff : 16'(dq[k]);
         end
      end
      case (fin_t.ctl.outcome)
         OUTCOME_KEEP: begin
            rsp_in = '{fin_t.w.cur_w, fin_t.w.cur_x, fin_t.w.cur_y, fin_t.w.cur_z,
                       OUTCOME_KEEP};
         end
         OUTCOME_TARGET: begin
            rsp_in = '{fin_t.w.tgt_w, fin_t.w.tgt_x, fin_t.w.tgt_y, fin_t.w.tgt_z,
                       OUTCOME_TARGET};
         end
         default: begin
            rsp_in = '{res[0], res[1], res[2], res[3], OUTCOME_INTERP};
         end
      endcase
   end

   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dq_vld[0];
      end
      if (adv) begin
         rsp_word_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
endmodule

// ===== bench/quaternion_rotate_towards_tb.sv =====
`timescale 1ns / 100ps

module quaternion_rotate_towards_tb;
   import qrt_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int QUIET_AFTER = 760;
   localparam int RANDOM_ITEMS = 830;

   typedef struct {
      bit           drain;
      req_word_type word;
   } pending_entry_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   pending_entry_type pending_words[$];
   rsp_word_type   expected_rotations[$];
   int             mismatch_count = 0;
   int             words_sent = 0;
   int             send_gap = 0;
   int             stall_left = 0;
   int             quiet_cycles = 0;
   int             outcome_seen[3] = '{0, 0, 0};
   int             results_seen = 0;
   bit             idling_on = 1'b1;

   localparam longint ANGLE_STEP[16] = '{
      51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   quaternion_rotate_towards u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned val);
      longint unsigned root, bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > val) bitpos = bitpos >> 2;
      while (bitpos != 0) begin
         if (val >= root + bitpos) begin
            val = val - (root + bitpos);
            root = (root >> 1) + bitpos;
         end else begin
            root = root >> 1;
         end
         bitpos = bitpos >> 2;
      end
      return root;
   endfunction

   function automatic longint arc_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += ANGLE_STEP[i];
         end else begin
            x -= dx; y += dy; z -= ANGLE_STEP[i];
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic longint arc_sine(longint z);
      longint x, y, dx, dy;
      x = longint'(GAIN_Q30);
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ANGLE_STEP[i];
         end else begin
            x += dx; y -= dy; z += ANGLE_STEP[i];
         end
      end
      return y;
   endfunction

   function automatic rsp_word_type predict_rotation(req_word_type w);
      longint cq[4], tq[4], v[4];
      longint lim, dotp, c, theta, lim16, a, b, r;
      longint unsigned sumsq, n, mag, q;
      rsp_word_type res;
      cq[0] = w.cur_w; cq[1] = w.cur_x; cq[2] = w.cur_y; cq[3] = w.cur_z;
      tq[0] = w.tgt_w; tq[1] = w.tgt_x; tq[2] = w.tgt_y; tq[3] = w.tgt_z;
      lim = longint'(w.step_limit);
      if (lim > longint'(PI_Q14)) lim = longint'(PI_Q14);
      if (lim < longint'(TINY_LIMIT)) begin
         res = '{w.cur_w, w.cur_x, w.cur_y, w.cur_z, OUTCOME_KEEP};
         return res;
      end
      dotp = 0;
      for (int k = 0; k < 4; k++) dotp += cq[k] * tq[k];
      dotp = dotp * 2;
      res = '{w.tgt_w, w.tgt_x, w.tgt_y, w.tgt_z, OUTCOME_TARGET};
      if (dotp > longint'(DOT_SNAP)) return res;
      if (dotp < 0) begin
         for (int k = 0; k < 4; k++) cq[k] = -cq[k];
         dotp = -dotp;
      end
      c = (dotp > longint'(ONE_Q30)) ? longint'(ONE_Q30) : dotp;
      theta = arc_angle(c, longint'(int_sqrt((64'd1 << 60) - longint'(c * c))));
      lim16 = lim * 4;
      if (theta < lim16) return res;
      a = arc_sine(theta - lim16);
      b = arc_sine(lim16);
      sumsq = 0;
      for (int k = 0; k < 4; k++) begin
         v[k] = (a * cq[k] + b * tq[k]) >>> 16;
         sumsq += longint'(v[k] * v[k]);
      end
      n = int_sqrt(sumsq);
      for (int k = 0; k < 4; k++) begin
         r = 0;
         if (n != 0) begin
            mag = (v[k] < 0) ? -v[k] : v[k];
            q = (mag * 32768 + n / 2) / n;
            if (v[k] < 0) r = (q > 32768) ? -32768 : -longint'(q);
            else r = (q > 32767) ? 32767 : longint'(q);
         end
         case (k)
            0: res.out_w = r[15:0];
            1: res.out_x = r[15:0];
            2: res.out_y = r[15:0];
            default: res.out_z = r[15:0];
         endcase
      end
      res.outcome = OUTCOME_INTERP;
      return res;
   endfunction

   task automatic report(string msg);
      $display("mismatch %0d: %s", mismatch_count, msg);
      mismatch_count++;
   endtask

   task automatic queue_word(logic [15:0] q[8], logic [15:0] lim);
      pending_entry_type e;
      e.drain = 1'b0;
      e.word = '{q[0], q[1], q[2], q[3], q[4], q[5], q[6], q[7], lim};
      pending_words = {pending_words, e};
   endtask

   task automatic unit_quat(output logic [15:0] q[4]);
      real c[4];
      real norm;
      do begin
         norm = 0.0;
         for (int k = 0; k < 4; k++) begin
            c[k] = real'(int'($urandom_range(0, 65535)) - 32768);
            norm += c[k] * c[k];
         end
      end while (norm < 1.0e6);
      norm = $sqrt(norm);
      for (int k = 0; k < 4; k++) q[k] = 16'($rtoi(c[k] * 32767.0 / norm));
   endtask

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 20));
         1: return 16'($urandom_range(17, 800));
         2: return 16'($urandom_range(800, 20000));
         3: return 16'($urandom_range(50000, 65535));
         default: return 16'($urandom);
      endcase
   endfunction

   // word driver
   always @(posedge clock) begin
      pending_entry_type e;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (!req_valid || !req_stall) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0 && pending_words[0].drain) begin
            req_valid <= 1'b0;
            if (!req_valid && expected_rotations.size() == 0)
               void'(pending_words.pop_front());
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            send_gap <= $urandom_range(0, 14);
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            e = pending_words.pop_front();
            req_word <= e.word;
            req_valid <= 1'b1;
            words_sent <= words_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver stall
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         stall_left <= $urandom_range(0, 14);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      rsp_word_type exp_word;
      if (!reset) begin
         if (req_valid && !req_stall)
            expected_rotations = {expected_rotations, predict_rotation(req_word)};
         if (rsp_valid && !rsp_stall) begin
            if (expected_rotations.size() == 0) begin
               report("result word with nothing expected");
            end else begin
               exp_word = expected_rotations.pop_front();
               results_seen++;
               if (exp_word.outcome < 3) outcome_seen[exp_word.outcome]++;
               if (rsp_word.out_w !== exp_word.out_w)
                  report($sformatf("out_w got %0d want %0d", rsp_word.out_w, exp_word.out_w));
               if (rsp_word.out_x !== exp_word.out_x)
                  report($sformatf("out_x got %0d want %0d", rsp_word.out_x, exp_word.out_x));
               if (rsp_word.out_y !== exp_word.out_y)
                  report($sformatf("out_y got %0d want %0d", rsp_word.out_y, exp_word.out_y));
               if (rsp_word.out_z !== exp_word.out_z)
                  report($sformatf("out_z got %0d want %0d", rsp_word.out_z, exp_word.out_z));
               if (rsp_word.outcome !== exp_word.outcome)
                  report($sformatf("outcome got %0d want %0d",
                                   rsp_word.outcome, exp_word.outcome));
            end
         end
         if (words_sent >= QUIET_AFTER) idling_on <= 1'b0;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout with %0d results outstanding", expected_rotations.size());
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [15:0] q[8];
      logic [15:0] a[4];
      logic [15:0] b[4];
      pending_entry_type marker;
      real t;
      int kind;

      // directed words
      q = '{16'h7fff, 0, 0, 0, 0, 16'h7fff, 0, 0};
      queue_word(q, 16'd0);
      queue_word(q, 16'd16);
      queue_word(q, 16'd17);
      queue_word(q, 16'd8000);
      queue_word(q, 16'hffff);
      queue_word(q, 16'd51472);
      q = '{16'h7fff, 0, 0, 0, 16'h7fff, 0, 0, 0};
      queue_word(q, 16'd100);
      q = '{16'h7fff, 0, 0, 0, 16'h8000, 0, 0, 0};
      queue_word(q, 16'd100);
      queue_word(q, 16'hffff);
      q = '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
            16'h8000};
      queue_word(q, 16'd3000);
      q = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
            16'h7fff};
      queue_word(q, 16'd3000);
      q = '{0, 0, 0, 0, 0, 0, 0, 0};
      queue_word(q, 16'd17);
      queue_word(q, 16'd40000);
      q = '{16'h5a82, 16'h5a82, 0, 0, 16'h7fff, 0, 0, 0};
      queue_word(q, 16'd12000);
      queue_word(q, 16'd13000);
      queue_word(q, 16'd500);
      q = '{16'h5a82, 16'h5a82, 0, 0, 16'h8001, 0, 0, 0};
      queue_word(q, 16'd500);
      q = '{16'h7fff, 0, 0, 0, 16'h7ffe, 16'h0100, 0, 0};
      queue_word(q, 16'd17);
      queue_word(q, 16'd20);

      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS / 2) begin
            marker.drain = 1'b1;
            marker.word = '0;
            pending_words = {pending_words, marker};
         end
         kind = $urandom_range(0, 9);
         unit_quat(a);
         if (kind < 4) begin
            unit_quat(b);
         end else if (kind < 7) begin
            t = $urandom_range(0, 1) ? 1.0 : -1.0;
            for (int k = 0; k < 4; k++)
               b[k] = 16'($rtoi(t * real'($signed(a[k]))) +
                          int'($urandom_range(0, 2000)) - 1000);
         end else if (kind < 9) begin
            for (int k = 0; k < 4; k++)
               b[k] = a[k] + 16'($urandom_range(0, 6)) - 16'd3;
         end else begin
            for (int k = 0; k < 4; k++) begin
               a[k] = 16'($urandom);
               b[k] = 16'($urandom);
            end
         end
         q = '{a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3]};
         queue_word(q, pick_limit());
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid || expected_rotations.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      while (expected_rotations.size() > 0) begin
         void'(expected_rotations.pop_front());
         report("expected result never arrived");
      end
      $display("%0d words sent, %0d results checked", words_sent, results_seen);
      $display("outcomes: kept %0d, snapped to target %0d, interpolated %0d",
               outcome_seen[0], outcome_seen[1], outcome_seen[2]);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/qrt_pkg.sv
rtl/qrt_sqrt.sv
rtl/qrt_cordic.sv
rtl/qrt_divider.sv
rtl/quaternion_rotate_towards.sv
bench/quaternion_rotate_towards_tb.sv
